// ===== sv/prim_minimum_spanning_tree_top_assert.svh =====
// Assertion macros for the minimum spanning tree block.
`ifndef PRIM_MINIMUM_SPANNING_TREE_TOP_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PMST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PMST_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PMST_ASSERT(lbl, clk, rst_n, prop, msg)
`define PMST_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== sv/prim_mst_pkg.sv =====
package prim_mst_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int COST_WIDTH   = 16;
    localparam int NODE_W       = 7;
    localparam int NODE_IW      = $clog2(MAX_VERTICES);
    localparam int EA_W         = $clog2(MAX_EDGES);
    localparam int CNT_W        = EA_W + 1;
    localparam int SEQ_W        = EA_W + 2;
    localparam int SUM_W        = 22;

    typedef struct packed {
        logic [NODE_W-1:0]            a;
        logic [NODE_W-1:0]            b;
        logic signed [COST_WIDTH-1:0] cost;
    } t_edge;

    typedef struct packed {
        logic [NODE_W-1:0]            from;
        logic [NODE_W-1:0]            to;
        logic signed [COST_WIDTH-1:0] cost;
        logic [SEQ_W-1:0]             seq;
    } t_cand;

    typedef enum logic [3:0] {
        S_IDLE, S_VISIT, S_SC_RD, S_SC_CHK, S_PU_TEST, S_PU_CMP, S_POP_CHK,
        S_PO_TOP, S_PO_LAST, S_SD_L, S_SD_R, S_SD_CMP, S_PO_DONE, S_FILL
    } t_state;

    function automatic logic cand_less(input t_cand x, input t_cand y);
        if (x.cost != y.cost) begin
            return x.cost < y.cost;
        end
        return x.seq < y.seq;
    endfunction
endpackage

// ===== sv/prim_mst_ram.sv =====
module prim_mst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/prim_minimum_spanning_tree_top.sv =====
// Minimum spanning tree engine (Prim, binary heap of candidate edges).
// Edges are loaded one per cycle: an edge transfer happens when start is
// high and busy is low. Edges with an endpoint of 0 or above the node count
// are ignored; edges beyond the store depth are dropped and flag overflow.
// The edge marked last_edge starts the run and busy rises on the next cycle.
// The run visits nodes from node 1; each visit scans the whole edge store
// through the edge memory (states S_SC_RD, S_SC_CHK for each edge), each heap
// push moves up one level per S_PU_TEST, S_PU_CMP pair and each pop moves down
// one level per S_SD_L, S_SD_R, S_SD_CMP sequence; pushes and pops share the
// single read port of the heap memory.
// Results come out as one-cycle strobes on o_strobe, max(n-1,1) per run, the
// final one marked by o_last_result. The receiver cannot stall. Missing tree
// slots of a disconnected graph come out as invalid zero edges.
// The node count register is written over the configuration channel while
// the block is idle. Reset clears the batch and sets the node count to 64;
// no clearing pass is needed, the block is ready right after reset.
`include "prim_minimum_spanning_tree_top_assert.svh"
module prim_minimum_spanning_tree_top
    import prim_mst_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [NODE_W-1:0]            i_edge_from,
    input  logic [NODE_W-1:0]            i_edge_to,
    input  logic signed [COST_WIDTH-1:0] i_edge_cost,
    input  logic                         i_last_edge,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [NODE_W-1:0]            i_cfg_data,
    output logic                         o_strobe,
    output logic [NODE_W-1:0]            o_tree_from,
    output logic [NODE_W-1:0]            o_tree_to,
    output logic                         o_edge_valid,
    output logic signed [SUM_W-1:0]      o_running_cost,
    output logic                         o_store_overflow,
    output logic                         o_last_result
);
    t_state                  r_state, n_state;
    logic [NODE_W-1:0]       r_nv, n_nv;
    logic [CNT_W-1:0]        r_ecnt, n_ecnt;
    logic                    r_ovf, n_ovf;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [CNT_W-1:0]        r_hsize, n_hsize;
    logic [SEQ_W-1:0]        r_seq, n_seq;
    logic [NODE_W-1:0]       r_node, n_node;
    logic [CNT_W-1:0]        r_scan, n_scan;
    t_cand                   r_cand, n_cand;
    logic [EA_W-1:0]         r_hidx, n_hidx;
    t_cand                   r_top, n_top;
    t_cand                   r_last, n_last;
    t_cand                   r_lchild, n_lchild;
    logic                    r_hasr, n_hasr;
    logic [NODE_W-1:0]       r_k, n_k;
    logic [NODE_W-1:0]       r_target, n_target;
    logic [NODE_W-1:0]       r_total, n_total;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                    r_strobe, n_strobe;
    logic [NODE_W-1:0]       r_ofrom, n_ofrom;
    logic [NODE_W-1:0]       r_oto, n_oto;
    logic                    r_ovalid, n_ovalid;
    logic signed [SUM_W-1:0] r_ocost, n_ocost;
    logic                    r_oovf, n_oovf;
    logic                    r_olast, n_olast;

    logic                    e_we;
    logic [EA_W-1:0]         e_waddr, e_raddr;
    t_edge                   e_wdata, e_rdata;
    logic                    h_we;
    logic [EA_W-1:0]         h_waddr, h_raddr;
    t_cand                   h_wdata, h_rdata;

    logic [NODE_W-1:0]       eff_n, other;
    logic [CNT_W-1:0]        par;
    logic [CNT_W:0]          lidx, ridx;
    logic                    accept;

    prim_mst_ram #(.WIDTH($bits(t_edge)), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    prim_mst_ram #(.WIDTH($bits(t_cand)), .DEPTH(MAX_EDGES)) u_heap_ram (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign accept      = start && !busy;

    always_comb begin
        if (r_nv == '0) begin
            eff_n = NODE_W'(1);
        end else if (r_nv > NODE_W'(MAX_VERTICES)) begin
            eff_n = NODE_W'(MAX_VERTICES);
        end else begin
            eff_n = r_nv;
        end
    end

    assign par  = (CNT_W'(r_hidx) - CNT_W'(1)) >> 1;
    assign lidx = {r_hidx, 1'b1} + (CNT_W+1)'(0);
    assign ridx = lidx + (CNT_W+1)'(1);
    assign other = (e_rdata.a == r_node) ? e_rdata.b : e_rdata.a;

    always_comb begin
        n_state = r_state; n_nv = r_nv; n_ecnt = r_ecnt; n_ovf = r_ovf;
        n_visited = r_visited; n_hsize = r_hsize; n_seq = r_seq; n_node = r_node;
        n_scan = r_scan; n_cand = r_cand; n_hidx = r_hidx; n_top = r_top;
        n_last = r_last; n_lchild = r_lchild; n_hasr = r_hasr; n_k = r_k;
        n_target = r_target; n_total = r_total; n_sum = r_sum;
        n_strobe = 1'b0; n_ofrom = r_ofrom; n_oto = r_oto; n_ovalid = r_ovalid;
        n_ocost = r_ocost; n_oovf = r_oovf; n_olast = r_olast;
        e_we = 1'b0; e_waddr = r_ecnt[EA_W-1:0];
        e_wdata = '{a: i_edge_from, b: i_edge_to, cost: i_edge_cost};
        e_raddr = r_scan[EA_W-1:0];
        h_we = 1'b0; h_waddr = r_hidx; h_wdata = r_cand; h_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_nv = i_cfg_data;
                end
                if (accept) begin
                    if (i_edge_from != '0 && i_edge_to != '0 &&
                        i_edge_from <= eff_n && i_edge_to <= eff_n) begin
                        if (r_ecnt < CNT_W'(MAX_EDGES)) begin
                            e_we = 1'b1;
                            n_ecnt = r_ecnt + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_last_edge) begin
                        n_state = S_VISIT;
                        n_node = NODE_W'(1);
                        n_k = '0;
                        n_sum = '0;
                        n_target = eff_n - NODE_W'(1);
                        n_total = (eff_n == NODE_W'(1)) ? NODE_W'(1) : eff_n - NODE_W'(1);
                    end
                end
            end
            S_VISIT: begin
                n_visited[NODE_IW'(r_node - NODE_W'(1))] = 1'b1;
                n_scan = '0;
                n_state = S_SC_RD;
            end
            S_SC_RD: begin
                n_state = (r_scan == r_ecnt) ? S_POP_CHK : S_SC_CHK;
            end
            S_SC_CHK: begin
                n_state = S_SC_RD;
                n_scan = r_scan + CNT_W'(1);
                if (e_rdata.a <= eff_n && e_rdata.b <= eff_n &&
                    (e_rdata.a == r_node || e_rdata.b == r_node) &&
                    !r_visited[NODE_IW'(other - NODE_W'(1))] &&
                    r_hsize < CNT_W'(MAX_EDGES)) begin
                    n_cand = '{from: r_node, to: other, cost: e_rdata.cost, seq: r_seq};
                    n_seq = r_seq + SEQ_W'(1);
                    n_hidx = r_hsize[EA_W-1:0];
                    n_hsize = r_hsize + CNT_W'(1);
                    n_scan = r_scan;
                    n_state = S_PU_TEST;
                end
            end
            S_PU_TEST: begin
                h_raddr = par[EA_W-1:0];
                if (r_hidx == '0) begin
                    h_we = 1'b1;
                    n_scan = r_scan + CNT_W'(1);
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                h_we = 1'b1;
                if (cand_less(r_cand, h_rdata)) begin
                    h_wdata = h_rdata;
                    n_hidx = par[EA_W-1:0];
                    n_state = S_PU_TEST;
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                    n_state = S_SC_RD;
                end
            end
            S_POP_CHK: begin
                h_raddr = '0;
                if (r_hsize != '0 && r_k < r_target) begin
                    n_state = S_PO_TOP;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_PO_TOP: begin
                n_top = h_rdata;
                n_hsize = r_hsize - CNT_W'(1);
                h_raddr = n_hsize[EA_W-1:0];
                n_state = (n_hsize == '0) ? S_PO_DONE : S_PO_LAST;
            end
            S_PO_LAST: begin
                n_last = h_rdata;
                n_hidx = '0;
                n_state = S_SD_L;
            end
            S_SD_L: begin
                h_raddr = lidx[EA_W-1:0];
                if (lidx >= (CNT_W+1)'(r_hsize)) begin
                    h_we = 1'b1;
                    h_wdata = r_last;
                    n_state = S_PO_DONE;
                end else begin
                    n_state = S_SD_R;
                end
            end
            S_SD_R: begin
                n_lchild = h_rdata;
                h_raddr = ridx[EA_W-1:0];
                n_hasr = ridx < (CNT_W+1)'(r_hsize);
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                h_we = 1'b1;
                if (r_hasr && cand_less(h_rdata, r_lchild)) begin
                    if (cand_less(h_rdata, r_last)) begin
                        h_wdata = h_rdata;
                        n_hidx = ridx[EA_W-1:0];
                        n_state = S_SD_L;
                    end else begin
                        h_wdata = r_last;
                        n_state = S_PO_DONE;
                    end
                end else if (cand_less(r_lchild, r_last)) begin
                    h_wdata = r_lchild;
                    n_hidx = lidx[EA_W-1:0];
                    n_state = S_SD_L;
                end else begin
                    h_wdata = r_last;
                    n_state = S_PO_DONE;
                end
            end
            S_PO_DONE: begin
                if (!r_visited[NODE_IW'(r_top.to - NODE_W'(1))]) begin
                    n_sum = r_sum + SUM_W'(r_top.cost);
                    n_strobe = 1'b1;
                    n_ofrom = r_top.from;
                    n_oto = r_top.to;
                    n_ovalid = 1'b1;
                    n_ocost = n_sum;
                    n_oovf = r_ovf;
                    n_olast = (r_k + NODE_W'(1) == r_total);
                    n_k = r_k + NODE_W'(1);
                    n_node = r_top.to;
                    n_state = (r_k + NODE_W'(1) == r_target) ? S_FILL : S_VISIT;
                end else begin
                    n_state = S_POP_CHK;
                end
            end
            S_FILL: begin
                if (r_k < r_total) begin
                    n_strobe = 1'b1;
                    n_ofrom = '0;
                    n_oto = '0;
                    n_ovalid = 1'b0;
                    n_ocost = r_sum;
                    n_oovf = r_ovf;
                    n_olast = (r_k + NODE_W'(1) == r_total);
                    n_k = r_k + NODE_W'(1);
                end
                if (r_k + NODE_W'(1) >= r_total) begin
                    n_ecnt = '0;
                    n_visited = '0;
                    n_hsize = '0;
                    n_ovf = 1'b0;
                    n_seq = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nv <= NODE_W'(MAX_VERTICES);
            r_ecnt <= '0;
            r_ovf <= 1'b0;
            r_visited <= '0;
            r_hsize <= '0;
            r_seq <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nv <= n_nv;
            r_ecnt <= n_ecnt;
            r_ovf <= n_ovf;
            r_visited <= n_visited;
            r_hsize <= n_hsize;
            r_seq <= n_seq;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node; r_scan <= n_scan; r_cand <= n_cand; r_hidx <= n_hidx;
        r_top <= n_top; r_last <= n_last; r_lchild <= n_lchild; r_hasr <= n_hasr;
        r_k <= n_k; r_target <= n_target; r_total <= n_total; r_sum <= n_sum;
        r_ofrom <= n_ofrom; r_oto <= n_oto; r_ovalid <= n_ovalid;
        r_ocost <= n_ocost; r_oovf <= n_oovf; r_olast <= n_olast;
    end

    assign o_strobe         = r_strobe;
    assign o_tree_from      = r_ofrom;
    assign o_tree_to        = r_oto;
    assign o_edge_valid     = r_ovalid;
    assign o_running_cost   = r_ocost;
    assign o_store_overflow = r_oovf;
    assign o_last_result    = r_olast;

    `PMST_ASSERT(a_strobe_busy, i_clk, i_rst_n, o_strobe && !o_last_result |-> busy, "result before end of run without busy")
    `PMST_ASSERT(a_heap_bound, i_clk, i_rst_n, r_hsize <= CNT_W'(MAX_EDGES), "heap size beyond depth")
    `PMST_ASSERT(a_valid_nodes, i_clk, i_rst_n, o_strobe && o_edge_valid |-> o_tree_to != '0 && o_tree_from != '0, "valid tree edge with zero node")
    `PMST_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_strobe && o_last_result, !busy, "block still busy after last result")
endmodule

// ===== dv/prim_minimum_spanning_tree_top_tb.sv =====
`timescale 1ns / 1ps
module prim_minimum_spanning_tree_top_tb
    import prim_mst_pkg::*;
();

    typedef struct {
        logic [NODE_W-1:0]            a;
        logic [NODE_W-1:0]            b;
        logic signed [COST_WIDTH-1:0] cost;
    } t_stored_edge;

    typedef struct {
        logic [NODE_W-1:0]            from;
        logic [NODE_W-1:0]            to;
        logic signed [COST_WIDTH-1:0] cost;
        int                           seq;
    } t_candidate;

    typedef struct {
        logic [NODE_W-1:0]       from;
        logic [NODE_W-1:0]       to;
        logic                    valid;
        logic signed [SUM_W-1:0] total;
        logic                    ovf;
        logic                    last;
    } t_tree_edge;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [NODE_W-1:0]            i_edge_from;
    logic [NODE_W-1:0]            i_edge_to;
    logic signed [COST_WIDTH-1:0] i_edge_cost;
    logic                         i_last_edge;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [NODE_W-1:0]            i_cfg_data;
    logic                         o_strobe;
    logic [NODE_W-1:0]            o_tree_from;
    logic [NODE_W-1:0]            o_tree_to;
    logic                         o_edge_valid;
    logic signed [SUM_W-1:0]      o_running_cost;
    logic                         o_store_overflow;
    logic                         o_last_result;

    prim_minimum_spanning_tree_top uut (.*);

    t_tree_edge   tree_edges_due[$];
    t_stored_edge batch_edges[$];
    logic [NODE_W-1:0] node_count_reg;
    logic         batch_overflow;
    int           errors;
    int           edges_sent;
    int           runs_done;
    int           results_seen;
    bit           burst_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int node_limit();
        if (node_count_reg == 0) return 1;
        if (node_count_reg > MAX_VERTICES) return MAX_VERTICES;
        return int'(node_count_reg);
    endfunction

    function automatic bit cand_before(t_candidate x, t_candidate y);
        if (x.cost != y.cost) return x.cost < y.cost;
        return x.seq < y.seq;
    endfunction

    task automatic grow_tree();
        bit         visited[MAX_VERTICES+1];
        t_candidate cands[$];
        t_candidate c;
        int         n;
        int         target;
        int         total;
        int         k;
        int         seq;
        int         node;
        int         best;
        int         other;
        int         sum;
        t_tree_edge r;
        n = node_limit();
        target = n - 1;
        total = (target < 1) ? 1 : target;
        k = 0;
        seq = 0;
        sum = 0;
        foreach (visited[i]) visited[i] = 1'b0;
        node = 1;
        forever begin
            visited[node] = 1'b1;
            foreach (batch_edges[i]) begin
                if (batch_edges[i].a > n || batch_edges[i].b > n) continue;
                if (batch_edges[i].a == node) other = int'(batch_edges[i].b);
                else if (batch_edges[i].b == node) other = int'(batch_edges[i].a);
                else continue;
                if (!visited[other] && cands.size() < MAX_EDGES) begin
                    c.from = NODE_W'(node);
                    c.to = NODE_W'(other);
                    c.cost = batch_edges[i].cost;
                    c.seq = seq++;
                    cands.insert(cands.size(), c);
                end
            end
            node = 0;
            while (cands.size() > 0 && k < target && node == 0) begin
                best = 0;
                foreach (cands[i]) if (cand_before(cands[i], cands[best])) best = i;
                c = cands[best];
                cands.delete(best);
                if (!visited[c.to]) begin
                    sum += c.cost;
                    r.from = c.from;
                    r.to = c.to;
                    r.valid = 1'b1;
                    r.total = SUM_W'(sum);
                    r.ovf = batch_overflow;
                    r.last = (k + 1 == total);
                    tree_edges_due.insert(tree_edges_due.size(), r);
                    k++;
                    node = int'(c.to);
                end
            end
            if (node == 0) break;
        end
        while (k < total) begin
            r.from = '0;
            r.to = '0;
            r.valid = 1'b0;
            r.total = SUM_W'(sum);
            r.ovf = batch_overflow;
            r.last = (k + 1 == total);
            tree_edges_due.insert(tree_edges_due.size(), r);
            k++;
        end
        batch_edges.delete();
        batch_overflow = 1'b0;
        runs_done++;
    endtask

    task automatic load_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                             logic signed [COST_WIDTH-1:0] cost, logic last);
        t_stored_edge e;
        int           n;
        n = node_limit();
        if (a >= 1 && b >= 1 && a <= n && b <= n) begin
            if (batch_edges.size() < MAX_EDGES) begin
                e.a = a;
                e.b = b;
                e.cost = cost;
                batch_edges.insert(batch_edges.size(), e);
            end else begin
                batch_overflow = 1'b1;
            end
        end
        if (last) grow_tree();
    endtask

    task automatic send_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                             logic signed [COST_WIDTH-1:0] cost, logic last);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_edge_from <= a;
        i_edge_to <= b;
        i_edge_cost <= cost;
        i_last_edge <= last;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        load_edge(a, b, cost, last);
        edges_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tree_edges_due.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_node_count(logic [NODE_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
        node_count_reg = value;
    endtask

    always @(posedge i_clk) begin
        t_tree_edge e;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (tree_edges_due.size() == 0) begin
                $display("%0t: unexpected result from=%0d to=%0d cost=%0d", $time,
                         o_tree_from, o_tree_to, o_running_cost);
                errors++;
            end else begin
                e = tree_edges_due.pop_front();
                if (o_tree_from !== e.from || o_tree_to !== e.to ||
                    o_edge_valid !== e.valid || o_running_cost !== e.total ||
                    o_store_overflow !== e.ovf || o_last_result !== e.last) begin
                    $display("%0t: expected from=%0d to=%0d valid=%0b cost=%0d ovf=%0b last=%0b",
                             $time, e.from, e.to, e.valid, e.total, e.ovf, e.last);
                    $display("%0t: actual   from=%0d to=%0d valid=%0b cost=%0d ovf=%0b last=%0b",
                             $time, o_tree_from, o_tree_to, o_edge_valid, o_running_cost,
                             o_store_overflow, o_last_result);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        write_node_count(7'd64);
        send_edge(7'd1, 7'd64, 16'sh7fff, 1'b0);
        send_edge(7'd64, 7'd63, 16'sh8000, 1'b0);
        send_edge(7'd0, 7'd2, 16'sd3, 1'b0);
        send_edge(7'd2, 7'd127, 16'sd3, 1'b1);
        write_node_count(7'd1);
        send_edge(7'd1, 7'd1, 16'sd9, 1'b1);
        write_node_count(7'd0);
        send_edge(7'd1, 7'd2, 16'sd4, 1'b1);
        write_node_count(7'd5);
        send_edge(7'd1, 7'd2, 16'sh8000, 1'b0);
        send_edge(7'd3, 7'd4, 16'sd7, 1'b0);
        send_edge(7'd1, 7'd6, 16'sd1, 1'b1);
        write_node_count(7'd4);
        send_edge(7'd1, 7'd2, 16'sd5, 1'b0);
        send_edge(7'd1, 7'd3, 16'sd5, 1'b0);
        send_edge(7'd2, 7'd3, 16'sd5, 1'b0);
        send_edge(7'd3, 7'd4, 16'sd5, 1'b0);
        send_edge(7'd4, 7'd2, 16'sd5, 1'b1);
        write_node_count(7'd127);
        send_edge(7'd64, 7'd1, 16'sd2, 1'b0);
        send_edge(7'd65, 7'd1, 16'sd2, 1'b1);
    endtask

    task automatic test_random_batches();
        int len;
        int n;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic signed [COST_WIDTH-1:0] cost;
        while (edges_sent < 170) begin
            case ($urandom_range(0, 9))
                0: write_node_count(NODE_W'($urandom_range(0, 127)));
                1: write_node_count(7'd64);
                2: write_node_count(7'd2);
                default: write_node_count(NODE_W'($urandom_range(2, 9)));
            endcase
            n = node_limit();
            len = $urandom_range(1, 14);
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    a = NODE_W'($urandom);
                    b = NODE_W'($urandom);
                end else begin
                    a = NODE_W'($urandom_range(1, n));
                    b = NODE_W'($urandom_range(1, n));
                end
                cost = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($signed($urandom_range(0, 6)) - 3);
                send_edge(a, b, cost, i == len - 1);
                if (i == len / 2 && $urandom_range(0, 4) == 0) drain();
            end
            burst_mode = 1'b0;
        end
    endtask

    initial begin
        int guard;
        errors = 0;
        edges_sent = 0;
        runs_done = 0;
        results_seen = 0;
        burst_mode = 1'b0;
        node_count_reg = 7'd64;
        batch_overflow = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_edge_from = '0;
        i_edge_to = '0;
        i_edge_cost = '0;
        i_last_edge = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_batches();
        start <= 1'b0;
        guard = 0;
        while (tree_edges_due.size() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
        if (tree_edges_due.size() > 0) begin
            $display("%0d expected results never arrived", tree_edges_due.size());
            errors++;
        end
        $display("Loaded %0d edges over %0d tree runs with varied node counts and gaps.",
                 edges_sent, runs_done);
        $display("Checked %0d tree edges with %0d mismatches.", results_seen, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/prim_mst_pkg.sv
sv/prim_mst_ram.sv
sv/prim_minimum_spanning_tree_top.sv
dv/prim_minimum_spanning_tree_top_tb.sv
